### sv/iosbc_pkg.sv
// types and constants shared by the io slot base compactor files
`timescale 1ns / 1ps

package iosbc_pkg;

    // item codes
    typedef enum logic [1:0] {
        ACT_MARK   = 2'd0,
        ACT_ASSIGN = 2'd1,
        ACT_FINISH = 2'd2,
        ACT_NOP    = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        KIND_NORMAL  = 2'd0,
        KIND_PERPRIM = 2'd1,
        KIND_OUTPUT  = 2'd2,
        KIND_NONE    = 2'd3
    } t_kind;

    // register indexes on the apb port
    localparam logic REG_INPUT_MODE  = 1'b0;
    localparam logic REG_OUTPUT_MODE = 1'b1;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // map bits counted per scan step
    localparam int CHUNK_LOG = 4;
    localparam int CHUNK_W   = 1 << CHUNK_LOG;

    typedef struct packed {
        t_action    action;
        t_kind      access_kind;
        logic [6:0] location;
        logic [5:0] slot_count;
        logic       half_precision;
        logic       upper_half;
        logic       upper_dvec2;
        logic       dual_blend;
    } t_in_word;

    typedef struct packed {
        logic [8:0] base;
        logic       matched;
        logic [7:0] input_count;
        logic [7:0] output_count;
        logic       any_renumbered;
    } t_out_word;

    // controller to datapath
    typedef struct packed {
        logic take;
        logic step;
        logic load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_scan;
        logic last_chunk;
    } t_dp_status;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_WAIT = 3'b100
    } t_state;

endpackage

### sv/iosbc_if.sv
// valid/ready channel interfaces for input and result words
`timescale 1ns / 1ps

interface iosbc_in_if import iosbc_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface iosbc_out_if import iosbc_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### sv/iosbc_ctrl.sv
// sequencer: accepts words, walks the map scan, owns the result valid flag
`timescale 1ns / 1ps

module iosbc_ctrl import iosbc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    // result register can take a new word this cycle
    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;

    assign o_cmd.take = i_in_valid && o_in_ready;
    assign o_cmd.step = (r_state == S_SCAN);
    assign o_cmd.load = (r_state == S_WAIT) && out_free;

    // state transitions
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.take && i_status.need_scan) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_status.last_chunk) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (o_cmd.load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // result valid: set on a new result, cleared when taken
    always_comb begin
        n_out_valid = r_out_valid;
        if ((o_cmd.take && !i_status.need_scan) || o_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

### sv/iosbc_dp.sv
// slot maps, range marking, chunked popcount accumulators and result register
`timescale 1ns / 1ps

module iosbc_dp import iosbc_pkg::*; #(
    parameter int SLOT_TOTAL = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in_word   i_word,
    input  logic       i_input_mode_on,
    input  logic       i_output_mode_on,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    output t_out_word  o_word
);

    localparam int NCHUNK = (SLOT_TOTAL + CHUNK_W - 1) / CHUNK_W;
    localparam int PAD_W  = NCHUNK * CHUNK_W;
    localparam int CIDX_W = $clog2(NCHUNK);
    localparam int ACC_W  = $clog2(3 * SLOT_TOTAL + 2);

    logic [SLOT_TOTAL-1:0] r_map_norm, r_map_pp, r_map_dbl, r_map_out;
    logic                  r_flag;

    // latched item for the scan
    logic        r_fin;
    t_kind       r_kind;
    logic [6:0]  r_loc;
    logic        r_dual;
    logic        r_dvec2;

    logic [CIDX_W-1:0] r_chunk;
    logic [ACC_W-1:0]  r_acc_a, r_acc_b;
    t_out_word         r_out_word;

    logic       is_in, is_out, enabled;
    logic [6:0] half_sum;
    logic [5:0] n_eff;
    logic [8:0] mark_end;
    logic [SLOT_TOTAL-1:0] mark_mask;
    logic       do_mark;

    logic [PAD_W-1:0]   pad_norm, pad_pp, pad_dbl, pad_out;
    logic [CHUNK_W-1:0] c_norm, c_pp, c_dbl, c_out;
    logic [CHUNK_W-1:0] lim_mask, full_mask;
    logic [CHUNK_W-1:0] m_norm, m_pp, m_dbl, m_out;
    logic [4:0]         pc_norm, pc_pp, pc_dbl, pc_out;
    logic [6:0]         sum_a;

    logic [ACC_W:0]  base_in;
    logic [8:0]      base_sel;
    logic [7:0]      sat_a, sat_b;
    t_out_word       imm_word, scan_word;

    // item classification
    assign is_in   = ((i_word.access_kind == KIND_NORMAL) ||
                      (i_word.access_kind == KIND_PERPRIM)) && i_input_mode_on;
    assign is_out  = (i_word.access_kind == KIND_OUTPUT) && i_output_mode_on;
    assign enabled = is_in || is_out;

    assign o_status.need_scan  = ((i_word.action == ACT_ASSIGN) && enabled) ||
                                 (i_word.action == ACT_FINISH);
    assign o_status.last_chunk = (r_chunk == CIDX_W'(NCHUNK - 1));

    // slot range covered by a mark, halved for medium precision
    assign half_sum = 7'(i_word.slot_count) + 7'(i_word.upper_half) + 7'd1;
    assign n_eff    = i_word.half_precision ? 6'(half_sum >> 1) : i_word.slot_count;
    assign mark_end = 9'(i_word.location) + 9'(n_eff);

    always_comb begin
        for (int j = 0; j < SLOT_TOTAL; j++) begin
            mark_mask[j] = (9'(j) >= 9'(i_word.location)) && (9'(j) < mark_end);
        end
    end

    assign do_mark = i_cmd.take && (i_word.action == ACT_MARK);

    // slot maps and renumbered flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_norm <= '0;
            r_map_pp   <= '0;
            r_map_dbl  <= '0;
            r_map_out  <= '0;
            r_flag     <= 1'b0;
        end else if (i_cmd.load && r_fin) begin
            r_map_norm <= '0;
            r_map_pp   <= '0;
            r_map_dbl  <= '0;
            r_map_out  <= '0;
            r_flag     <= 1'b0;
        end else if (i_cmd.load) begin
            r_flag <= 1'b1;
        end else if (do_mark) begin
            if (is_in) begin
                if (i_word.access_kind == KIND_PERPRIM) begin
                    r_map_pp <= r_map_pp | mark_mask;
                end else begin
                    r_map_norm <= r_map_norm | mark_mask;
                end
                if (i_word.upper_dvec2) begin
                    r_map_dbl <= r_map_dbl | mark_mask;
                end
            end else if (is_out && !i_word.dual_blend) begin
                r_map_out <= r_map_out | mark_mask;
            end
        end
    end

    // current chunk of every map
    assign pad_norm = PAD_W'(r_map_norm);
    assign pad_pp   = PAD_W'(r_map_pp);
    assign pad_dbl  = PAD_W'(r_map_dbl);
    assign pad_out  = PAD_W'(r_map_out);

    assign c_norm = pad_norm[{r_chunk, {CHUNK_LOG{1'b0}}} +: CHUNK_W];
    assign c_pp   = pad_pp[{r_chunk, {CHUNK_LOG{1'b0}}} +: CHUNK_W];
    assign c_dbl  = pad_dbl[{r_chunk, {CHUNK_LOG{1'b0}}} +: CHUNK_W];
    assign c_out  = pad_out[{r_chunk, {CHUNK_LOG{1'b0}}} +: CHUNK_W];

    // bits of this chunk below the item location
    always_comb begin
        for (int b = 0; b < CHUNK_W; b++) begin
            lim_mask[b] = 9'({r_chunk, CHUNK_LOG'(b)}) < 9'(r_loc);
        end
    end
    assign full_mask = '1;

    // which maps count fully, up to the location, or not at all
    always_comb begin
        m_norm = '0;
        m_pp   = '0;
        m_dbl  = '0;
        m_out  = '0;
        if (r_fin) begin
            m_norm = full_mask;
            m_out  = full_mask;
        end else begin
            case (r_kind)
                KIND_NORMAL: begin
                    m_norm = lim_mask;
                    m_dbl  = lim_mask;
                end
                KIND_PERPRIM: begin
                    m_norm = full_mask;
                    m_dbl  = full_mask;
                    m_pp   = lim_mask;
                end
                KIND_OUTPUT: begin
                    m_out = r_dual ? full_mask : lim_mask;
                end
                default: begin
                    m_norm = '0;
                end
            endcase
        end
    end

    assign pc_norm = 5'($countones(c_norm & m_norm));
    assign pc_pp   = 5'($countones(c_pp & m_pp));
    assign pc_dbl  = 5'($countones(c_dbl & m_dbl));
    assign pc_out  = 5'($countones(c_out & m_out));
    assign sum_a   = 7'(pc_norm) + 7'(pc_pp) + 7'(pc_dbl);

    // item latch, chunk counter and accumulators
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_fin   <= (i_word.action == ACT_FINISH);
            r_kind  <= i_word.access_kind;
            r_loc   <= i_word.location;
            r_dual  <= i_word.dual_blend;
            r_dvec2 <= i_word.upper_dvec2 && (i_word.access_kind == KIND_NORMAL);
            r_chunk <= '0;
            r_acc_a <= '0;
            r_acc_b <= '0;
        end else if (i_cmd.step) begin
            r_chunk <= r_chunk + CIDX_W'(1);
            r_acc_a <= r_acc_a + ACC_W'(sum_a);
            r_acc_b <= r_acc_b + ACC_W'(pc_out);
        end
    end

    // result of a word that needs no scan
    always_comb begin
        imm_word                = '0;
        imm_word.matched        = (i_word.action == ACT_MARK) && enabled;
        imm_word.any_renumbered = r_flag;
    end

    // result of an assign or finish scan
    assign base_in  = {1'b0, r_acc_a} + (ACC_W + 1)'(r_dvec2);
    assign base_sel = (r_kind == KIND_OUTPUT) ? 9'(r_acc_b) : 9'(base_in);
    assign sat_a    = (32'(r_acc_a) > 32'd255) ? 8'hff : 8'(r_acc_a);
    assign sat_b    = (32'(r_acc_b) > 32'd255) ? 8'hff : 8'(r_acc_b);

    always_comb begin
        scan_word = '0;
        if (r_fin) begin
            scan_word.input_count    = i_input_mode_on ? sat_a : 8'd0;
            scan_word.output_count   = i_output_mode_on ? sat_b : 8'd0;
            scan_word.any_renumbered = r_flag;
        end else begin
            scan_word.base           = base_sel;
            scan_word.matched        = 1'b1;
            scan_word.any_renumbered = 1'b1;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_word <= scan_word;
        end else if (i_cmd.take && !o_status.need_scan) begin
            r_out_word <= imm_word;
        end
    end

    assign o_word = r_out_word;

endmodule

### sv/io_slot_base_compactor_top.sv
// top level of the io slot base compactor: channels, apb registers, controller and datapath
//
//  port      dir  handshake              word
//  i_in_ch   in   valid/ready            t_in_word: action, kind, location, count, flags
//  o_out_ch  out  valid/ready            t_out_word: base, matched, counts, renumbered flag
//  apb       in   psel/penable, pready   reg 0 input_mode_on (0x0), reg 1 output_mode_on (0x4)
//
//  mark, no-op and disabled words: the result is registered in the cycle after the word is accepted.
//  enabled assign words and finish words: taken, then scanned by the 16-bit popcount step that
//  walks the four slot maps chunk by chunk, then loaded into the result register once it is free.
//  reset (synchronous, i_rst_n low) clears all maps and the renumbered flag, both modes on.
//  a new word is taken when the block is idle and the result register is free or being taken;
//  a stalled result holds in the result register.
`timescale 1ns / 1ps

module io_slot_base_compactor_top import iosbc_pkg::*; #(
    parameter int SLOT_TOTAL = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    iosbc_in_if.sink           i_in_ch,
    iosbc_out_if.source        o_out_ch,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic       r_input_mode_on, r_output_mode_on;
    logic       cfg_wr;
    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;
    t_out_word  out_word;

    // apb register file
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_input_mode_on  <= 1'b1;
            r_output_mode_on <= 1'b1;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_INPUT_MODE:  r_input_mode_on  <= pwdata[0];
                REG_OUTPUT_MODE: r_output_mode_on <= pwdata[0];
                default:         r_input_mode_on  <= r_input_mode_on;
            endcase
        end
    end

    // register read back
    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            REG_INPUT_MODE:  prdata = PDATA_W'(r_input_mode_on);
            REG_OUTPUT_MODE: prdata = PDATA_W'(r_output_mode_on);
            default:         prdata = '0;
        endcase
    end

    // sequencer
    iosbc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_ch.valid),
        .o_in_ready  (i_in_ch.ready),
        .o_out_valid (o_out_ch.valid),
        .i_out_ready (o_out_ch.ready),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    // maps and counting
    iosbc_dp #(
        .SLOT_TOTAL (SLOT_TOTAL)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_word           (i_in_ch.data),
        .i_input_mode_on  (r_input_mode_on),
        .i_output_mode_on (r_output_mode_on),
        .i_cmd            (dp_cmd),
        .o_status         (dp_status),
        .o_word           (out_word)
    );

    assign o_out_ch.data = out_word;

endmodule

### test/tb_io_slot_base_compactor_top.sv
// self-checking testbench for the io slot base compactor top level
`timescale 1ns / 1ps

module tb_io_slot_base_compactor_top;
    import iosbc_pkg::*;

    localparam int SLOTS     = 128;
    localparam int FAIL_SHOW = 50;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    iosbc_in_if  in_ch ();
    iosbc_out_if out_ch ();

    io_slot_base_compactor_top #(
        .SLOT_TOTAL (SLOTS)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // shadow of the block state
    logic [SLOTS-1:0] normal_used;
    logic [SLOTS-1:0] perprim_used;
    logic [SLOTS-1:0] double_used;
    logic [SLOTS-1:0] output_used;
    logic             renumbered;
    logic             input_on;
    logic             output_on;

    t_out_word base_q[$];
    int        n_fail;
    int        n_sent;
    bit        quiet;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

    // set bits of a map strictly below a slot position
    function automatic int count_below(logic [SLOTS-1:0] m, int lim);
        int c;
        c = 0;
        for (int i = 0; i < SLOTS; i++) begin
            if (i < lim && m[i]) c++;
        end
        return c;
    endfunction

    // expected result word for one accepted word, updating the shadow state
    function automatic t_out_word predict_base(t_in_word w);
        t_out_word r;
        logic      in_hit;
        logic      out_hit;
        int        span;
        int        first;
        int        b;
        r       = '0;
        in_hit  = (w.access_kind == KIND_NORMAL || w.access_kind == KIND_PERPRIM) && input_on;
        out_hit = (w.access_kind == KIND_OUTPUT) && output_on;
        span    = w.slot_count;
        first   = w.location;
        if (w.half_precision) span = (span + int'(w.upper_half) + 1) / 2;
        r.any_renumbered = renumbered;
        case (w.action)
            ACT_MARK: begin
                if (in_hit || out_hit) begin
                    r.matched = 1'b1;
                    for (int s = first; s < first + span; s++) begin
                        if (s < SLOTS) begin
                            if (in_hit) begin
                                if (w.access_kind == KIND_PERPRIM) perprim_used[s] = 1'b1;
                                else normal_used[s] = 1'b1;
                                if (w.upper_dvec2) double_used[s] = 1'b1;
                            end else if (!w.dual_blend) begin
                                output_used[s] = 1'b1;
                            end
                        end
                    end
                end
            end
            ACT_ASSIGN: begin
                if (in_hit || out_hit) begin
                    r.matched = 1'b1;
                    if (in_hit && w.access_kind == KIND_PERPRIM)
                        b = count_below(normal_used, SLOTS) + count_below(double_used, SLOTS)
                            + count_below(perprim_used, first);
                    else if (in_hit)
                        b = count_below(normal_used, first) + count_below(double_used, first)
                            + int'(w.upper_dvec2);
                    else if (w.dual_blend)
                        b = count_below(output_used, SLOTS);
                    else
                        b = count_below(output_used, first);
                    r.base           = 9'(b);
                    renumbered       = 1'b1;
                    r.any_renumbered = 1'b1;
                end
            end
            ACT_FINISH: begin
                if (input_on) r.input_count = 8'(count_below(normal_used, SLOTS));
                if (output_on) r.output_count = 8'(count_below(output_used, SLOTS));
                normal_used  = '0;
                perprim_used = '0;
                double_used  = '0;
                output_used  = '0;
                renumbered   = 1'b0;
            end
            default: ;
        endcase
        n_sent++;
        return r;
    endfunction

    function automatic t_in_word make_word(t_action act, t_kind kind, int loc, int cnt,
                                           bit half, bit upper, bit dvec2, bit dual);
        t_in_word w;
        w.action         = act;
        w.access_kind    = kind;
        w.location       = 7'(loc);
        w.slot_count     = 6'(cnt);
        w.half_precision = half;
        w.upper_half     = upper;
        w.upper_dvec2    = dvec2;
        w.dual_blend     = dual;
        return w;
    endfunction

    // random word of a given action, small spans most of the time
    function automatic t_in_word random_word(t_action act);
        t_kind kind;
        int    loc;
        int    cnt;
        kind = ($urandom_range(0, 15) == 0) ? KIND_NONE : t_kind'(2'($urandom_range(0, 2)));
        loc  = $urandom_range(0, 1) ? $urandom_range(0, 127) : $urandom_range(0, 47);
        cnt  = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 6);
        return make_word(act, kind, loc, cnt, $urandom_range(0, 3) == 0,
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
    endfunction

    // fully random word, any action and kind
    function automatic t_in_word noise_word();
        return t_in_word'($bits(t_in_word)'($urandom));
    endfunction

    // send one word, with an optional idle burst first
    task automatic send_word(input t_in_word w);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        do @(posedge i_clk); while (!in_ch.ready);
        base_q.push_back(predict_base(w));
    endtask

    // stop sending and wait until every expected word has come back
    task automatic wait_results_done();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (base_q.size() != 0);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic idx, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_INPUT_MODE) input_on = value[0];
        else output_on = value[0];
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_modes(input bit in_on, input bit out_on);
        wait_results_done();
        apb_write(REG_INPUT_MODE, PDATA_W'(in_on));
        apb_write(REG_OUTPUT_MODE, PDATA_W'(out_on));
    endtask

    // field extremes, every action and kind, out-of-table and dual-blend cases
    task automatic test_directed();
        send_word(make_word(ACT_MARK, KIND_NORMAL, 0, 0, 0, 0, 0, 0));
        send_word(make_word(ACT_MARK, KIND_NORMAL, 2, 3, 0, 0, 0, 0));
        send_word(make_word(ACT_MARK, KIND_NORMAL, 8, 2, 0, 0, 1, 0));
        send_word(make_word(ACT_MARK, KIND_PERPRIM, 0, 63, 1, 1, 0, 0));
        send_word(make_word(ACT_MARK, KIND_NORMAL, 20, 0, 1, 0, 0, 0));
        send_word(make_word(ACT_MARK, KIND_NORMAL, 127, 63, 0, 0, 0, 0));
        send_word(make_word(ACT_MARK, KIND_OUTPUT, 120, 63, 0, 0, 0, 0));
        send_word(make_word(ACT_MARK, KIND_OUTPUT, 0, 5, 0, 0, 0, 1));
        send_word(make_word(ACT_MARK, KIND_NONE, 0, 4, 0, 0, 0, 0));
        send_word(make_word(ACT_ASSIGN, KIND_NORMAL, 127, 0, 0, 0, 0, 0));
        send_word(make_word(ACT_ASSIGN, KIND_NORMAL, 9, 0, 0, 0, 1, 0));
        send_word(make_word(ACT_ASSIGN, KIND_PERPRIM, 127, 0, 0, 0, 0, 0));
        send_word(make_word(ACT_ASSIGN, KIND_PERPRIM, 0, 0, 0, 0, 0, 0));
        send_word(make_word(ACT_ASSIGN, KIND_OUTPUT, 0, 0, 0, 0, 0, 0));
        send_word(make_word(ACT_ASSIGN, KIND_OUTPUT, 127, 0, 0, 0, 0, 0));
        send_word(make_word(ACT_ASSIGN, KIND_OUTPUT, 0, 0, 0, 0, 0, 1));
        send_word(make_word(ACT_ASSIGN, KIND_NONE, 64, 0, 0, 0, 0, 0));
        send_word(make_word(ACT_NOP, KIND_NORMAL, 127, 63, 1, 1, 1, 1));
        send_word(make_word(ACT_FINISH, KIND_NORMAL, 0, 0, 0, 0, 0, 0));
        send_word(make_word(ACT_FINISH, KIND_OUTPUT, 0, 0, 0, 0, 0, 0));
        send_word(make_word(ACT_NOP, KIND_NONE, 0, 0, 0, 0, 0, 0));
    endtask

    // short mark / assign / finish pass under one mode setting
    task automatic mode_pass();
        send_word(make_word(ACT_MARK, KIND_NORMAL, 1, 4, 0, 0, 1, 0));
        send_word(make_word(ACT_MARK, KIND_PERPRIM, 10, 3, 0, 0, 0, 0));
        send_word(make_word(ACT_MARK, KIND_OUTPUT, 5, 6, 0, 0, 0, 0));
        send_word(make_word(ACT_ASSIGN, KIND_NORMAL, 3, 0, 0, 0, 0, 0));
        send_word(make_word(ACT_ASSIGN, KIND_PERPRIM, 12, 0, 0, 0, 0, 0));
        send_word(make_word(ACT_ASSIGN, KIND_OUTPUT, 8, 0, 0, 0, 0, 1));
        send_word(make_word(ACT_FINISH, KIND_NONE, 0, 0, 0, 0, 0, 0));
    endtask

    // all four mode settings, and a finish under a disabled mode still clears
    task automatic test_mode_settings();
        set_modes(0, 0);
        mode_pass();
        set_modes(1, 0);
        mode_pass();
        set_modes(0, 1);
        mode_pass();
        set_modes(1, 1);
        mode_pass();
        send_word(make_word(ACT_MARK, KIND_OUTPUT, 0, 20, 0, 0, 0, 0));
        send_word(make_word(ACT_MARK, KIND_NORMAL, 0, 20, 0, 0, 0, 0));
        set_modes(0, 0);
        send_word(make_word(ACT_FINISH, KIND_NONE, 0, 0, 0, 0, 0, 0));
        set_modes(1, 1);
        send_word(make_word(ACT_FINISH, KIND_NONE, 0, 0, 0, 0, 0, 0));
    endtask

    // one shader-like sequence: marks, assigns, usually a finish, some noise mixed in
    task automatic run_sequence();
        int n_mark;
        int n_assign;
        n_mark   = $urandom_range(1, 8);
        n_assign = $urandom_range(1, 8);
        for (int i = 0; i < n_mark; i++)
            send_word(($urandom_range(0, 9) == 0) ? noise_word() : random_word(ACT_MARK));
        for (int i = 0; i < n_assign; i++)
            send_word(($urandom_range(0, 9) == 0) ? noise_word() : random_word(ACT_ASSIGN));
        if ($urandom_range(0, 7) != 0) send_word(random_word(ACT_FINISH));
    endtask

    task automatic test_random_sequences(input int target);
        int start;
        start = n_sent;
        while (n_sent - start < target) begin
            if ($urandom_range(0, 9) == 0)
                set_modes($urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0);
            run_sequence();
        end
    endtask

    // sender holds off until the block has drained, then resumes
    task automatic test_drain_pause();
        for (int i = 0; i < 3; i++) run_sequence();
        wait_results_done();
        for (int i = 0; i < 3; i++) run_sequence();
    endtask

    // closing stretch with both sides at full rate
    task automatic test_full_rate_tail();
        set_modes(1, 1);
        quiet = 1'b1;
        test_random_sequences(100);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            if (n_fail < FAIL_SHOW) $error("%s: expected %0d, actual %0d", name, want, got);
            n_fail++;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (base_q.size() == 0) begin
                if (n_fail < FAIL_SHOW) $error("result word with nothing expected");
                n_fail++;
            end else begin
                want = base_q.pop_front();
                check_field("base", want.base, out_ch.data.base);
                check_field("matched", want.matched, out_ch.data.matched);
                check_field("input_count", want.input_count, out_ch.data.input_count);
                check_field("output_count", want.output_count, out_ch.data.output_count);
                check_field("any_renumbered", want.any_renumbered, out_ch.data.any_renumbered);
            end
        end
    end

    // result side stalls in random bursts
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            if (!quiet && $urandom_range(0, 2) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    end

    // test sequence
    initial begin
        n_fail       = 0;
        n_sent       = 0;
        quiet        = 1'b0;
        normal_used  = '0;
        perprim_used = '0;
        double_used  = '0;
        output_used  = '0;
        renumbered   = 1'b0;
        input_on     = 1'b1;
        output_on    = 1'b1;
        i_rst_n      <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.data   <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_mode_settings();
        test_drain_pause();
        test_random_sequences(840);
        test_full_rate_tail();

        wait_results_done();
        if (n_fail == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
